[design/bpcr_pkg.sv]
// ----------------------------------------------------------------------------
// bpcr_pkg
// Types and fixed constants of the ball pair collision resolve unit.
// ----------------------------------------------------------------------------
package bpcr_pkg;

	localparam logic [17:0] RESTI_ONE   = 18'd65536;
	localparam logic [16:0] RESTI_RESET = 17'd46334;

	// pipeline geometry
	localparam int ROOT_W  = 34;                 // integer square root width
	localparam int SQ_W    = 2 * ROOT_W;         // radicand width
	localparam int NUM_W   = 64;                 // divider numerator width
	localparam int DEN_W   = ROOT_W;             // divider denominator width
	localparam int QUO_W   = 32;                 // divider quotient width
	localparam int ST_SUM  = 4;                  // squared distance and contact test
	localparam int ST_ROOT = ST_SUM + ROOT_W;    // distance ready
	localparam int ST_QUO  = ST_ROOT + QUO_W;    // normal and mass ratios ready
	localparam int LAT     = ST_QUO + 10;        // result register

	typedef struct packed {
		logic signed [31:0] first_pos_x;
		logic signed [31:0] first_pos_y;
		logic signed [31:0] first_vel_x;
		logic signed [31:0] first_vel_y;
		logic [30:0]        first_radius;
		logic [30:0]        first_mass;
		logic signed [31:0] second_pos_x;
		logic signed [31:0] second_pos_y;
		logic signed [31:0] second_vel_x;
		logic signed [31:0] second_vel_y;
		logic [30:0]        second_radius;
		logic [30:0]        second_mass;
	} bpcr_in_t;

	typedef struct packed {
		logic signed [31:0] new_first_pos_x;
		logic signed [31:0] new_first_pos_y;
		logic signed [31:0] new_first_vel_x;
		logic signed [31:0] new_first_vel_y;
		logic signed [31:0] new_second_pos_x;
		logic signed [31:0] new_second_pos_y;
		logic signed [31:0] new_second_vel_x;
		logic signed [31:0] new_second_vel_y;
		logic               collided;
	} bpcr_out_t;

	// what travels down the pipeline next to the arithmetic
	typedef struct packed {
		bpcr_in_t           item;
		logic               dx_neg;
		logic               dy_neg;
		logic [32:0]        dx_mag;
		logic [32:0]        dy_mag;
		logic [31:0]        rsum;
		logic [31:0]        msum;
		logic               collided;
		logic [31:0]        corr;
		logic [31:0]        qx;
		logic [31:0]        qy;
		logic [31:0]        q1;
		logic [31:0]        q2;
		logic signed [35:0] px;
		logic signed [35:0] py;
	} bpcr_pay_t;

endpackage

[design/bpcr_if.sv]
// ----------------------------------------------------------------------------
// bpcr_if
// Valid/ready channels for circle pairs and resolved results.
// ----------------------------------------------------------------------------
interface bpcr_pair_if import bpcr_pkg::*;;
	logic     valid;
	logic     ready;
	bpcr_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bpcr_result_if import bpcr_pkg::*;;
	logic      valid;
	logic      ready;
	bpcr_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/bpcr_isqrt.sv]
// ----------------------------------------------------------------------------
// bpcr_isqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module bpcr_isqrt #(
	parameter int IN_W = 68
) (
	input  logic                clk,
	input  logic                en,
	input  logic [IN_W-1:0]     x,
	output logic [IN_W/2-1:0]   root
);
	localparam int RW = IN_W / 2;
	localparam int MW = RW + 1;

	logic [MW-1:0]   rem_q  [RW];
	logic [RW-1:0]   root_q [RW];
	logic [IN_W-1:0] x_q    [RW];

	genvar j;
	generate
		for (j = 0; j < RW; j++) begin : g_stage
			logic [MW-1:0]   rem_i;
			logic [RW-1:0]   root_i;
			logic [IN_W-1:0] x_i;
			logic [MW+1:0]   t;
			logic [MW+1:0]   trial;
			logic            ge;

			if (j == 0) begin : g_first
				assign rem_i  = '0;
				assign root_i = '0;
				assign x_i    = x;
			end else begin : g_next
				assign rem_i  = rem_q[j-1];
				assign root_i = root_q[j-1];
				assign x_i    = x_q[j-1];
			end

			// bring down the next two radicand bits and try root*4+1
			assign t     = {rem_i, x_i[IN_W-1:IN_W-2]};
			assign trial = {1'b0, root_i, 2'b01};
			assign ge    = (t >= trial);

			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[j]  <= ge ? MW'(t - trial) : MW'(t);
					root_q[j] <= {root_i[RW-2:0], ge};
					x_q[j]    <= {x_i[IN_W-3:0], 2'b00};
				end
			end
		end
	endgenerate

	assign root = root_q[RW-1];
endmodule

[design/bpcr_div.sv]
// ----------------------------------------------------------------------------
// bpcr_div
// Pipelined restoring divider, one quotient bit per stage. The top bits of
// the numerator above the quotient width must be below the divisor.
// ----------------------------------------------------------------------------
module bpcr_div #(
	parameter int NW = 64,
	parameter int DW = 34,
	parameter int QW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);
	logic [DW-1:0] rem_q [QW];
	logic [QW-1:0] low_q [QW];
	logic [DW-1:0] den_q [QW];
	logic [QW-1:0] quo_q [QW];

	genvar j;
	generate
		for (j = 0; j < QW; j++) begin : g_stage
			logic [DW-1:0] rem_i;
			logic [QW-1:0] low_i;
			logic [DW-1:0] den_i;
			logic [QW-1:0] quo_i;
			logic [DW:0]   t;
			logic          ge;

			if (j == 0) begin : g_first
				assign rem_i = DW'(num[NW-1:QW]);
				assign low_i = num[QW-1:0];
				assign den_i = den;
				assign quo_i = '0;
			end else begin : g_next
				assign rem_i = rem_q[j-1];
				assign low_i = low_q[j-1];
				assign den_i = den_q[j-1];
				assign quo_i = quo_q[j-1];
			end

			assign t  = {rem_i, low_i[QW-1]};
			assign ge = (t >= {1'b0, den_i});

			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[j] <= ge ? DW'(t - {1'b0, den_i}) : t[DW-1:0];
					low_q[j] <= {low_i[QW-2:0], 1'b0};
					den_q[j] <= den_i;
					quo_q[j] <= {quo_i[QW-2:0], ge};
				end
			end
		end
	endgenerate

	assign quo = quo_q[QW-1];
endmodule

[design/ball_pair_collision_resolve_unit.sv]
// ----------------------------------------------------------------------------
// ball_pair_collision_resolve_unit
// Circle pair contact test, separation along the unit normal and restitution
// velocity response, fully pipelined in signed Q16.16.
// ----------------------------------------------------------------------------
// Throughput: one pair per cycle while no result beat waits; the 34-stage square root and the 32-stage
// dividers each retire one bit per stage.
// A result beat that waits freezes the whole pipeline, nothing is dropped.
// Reset clears all valid bits and loads restitution with 46334 (about 0.707).
// ----------------------------------------------------------------------------
module ball_pair_collision_resolve_unit import bpcr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	bpcr_pair_if.sink            pair,
	bpcr_result_if.source        result,
	input  logic                 cfg_we,
	input  logic [16:0]          cfg_wdata
);
	localparam logic [31:0] UNIT_MAX = 32'd1073741825;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic [33:0] rnd30(input logic [63:0] p);
		logic [63:0] t;
		t = p + 64'd536870912;
		return t[63:30];
	endfunction

	function automatic logic signed [35:0] sgn36(input logic n, input logic [33:0] m);
		return n ? -$signed({2'b00, m}) : $signed({2'b00, m});
	endfunction

	function automatic logic signed [42:0] sgn43(input logic n, input logic [41:0] m);
		return n ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
		if (v > 44'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -44'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	logic [16:0]     restitution_q;
	logic [LAT:1]    valid_q;
	logic            adv;
	bpcr_pay_t       pay_in;
	bpcr_pay_t       pay_q   [1:LAT-1];
	bpcr_pay_t       pay_nxt [2:LAT-1];

	// ---- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restitution_q <= RESTI_RESET;
		end else if (cfg_we) begin
			restitution_q <= cfg_wdata;
		end
	end

	// ---- flow control: advance unless the result beat is held
	assign adv         = !valid_q[LAT] || result.ready;
	assign pair.ready  = adv;
	assign result.valid = valid_q[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv) begin
			valid_q <= {valid_q[LAT-1:1], pair.valid};
		end
	end

	// ---- stage 2: differences and sums
	logic signed [32:0] dx_d, dy_d;
	assign dx_d = {pay_q[1].item.second_pos_x[31], pay_q[1].item.second_pos_x}
		- {pay_q[1].item.first_pos_x[31], pay_q[1].item.first_pos_x};
	assign dy_d = {pay_q[1].item.second_pos_y[31], pay_q[1].item.second_pos_y}
		- {pay_q[1].item.first_pos_y[31], pay_q[1].item.first_pos_y};

	// ---- stage 3: squares
	logic [65:0] dx2_s3, dy2_s3;
	logic [63:0] rr_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			dx2_s3 <= pay_q[2].dx_mag * pay_q[2].dx_mag;
			dy2_s3 <= pay_q[2].dy_mag * pay_q[2].dy_mag;
			rr_s3  <= pay_q[2].rsum * pay_q[2].rsum;
		end
	end

	// ---- stage 4: squared distance and contact test
	logic [66:0] sq_d, sq_s4;
	logic        coll_d;
	assign sq_d   = {1'b0, dx2_s3} + {1'b0, dy2_s3};
	assign coll_d = (sq_d != '0) && (sq_d <= {3'b000, rr_s3});
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s4 <= sq_d;
		end
	end

	// ---- distance
	logic [ROOT_W-1:0] dist_root;
	bpcr_isqrt #(.IN_W(SQ_W)) u_isqrt (
		.clk  (clk),
		.en   (adv),
		.x    ({1'b0, sq_s4}),
		.root (dist_root)
	);

	logic [33:0] gap_d;
	assign gap_d = {2'b00, pay_q[ST_ROOT].rsum} - dist_root;

	// ---- unit normal and mass ratios
	logic [NUM_W-1:0] num_x, num_y, num_1, num_2;
	logic [DEN_W-1:0] den_m;
	logic [QUO_W-1:0] qx, qy, q1, q2;

	assign num_x = {1'b0, pay_q[ST_ROOT].dx_mag, 30'b0} + {31'b0, dist_root[ROOT_W-1:1]};
	assign num_y = {1'b0, pay_q[ST_ROOT].dy_mag, 30'b0} + {31'b0, dist_root[ROOT_W-1:1]};
	assign num_1 = {3'b000, pay_q[ST_ROOT].item.first_mass, 30'b0}
		+ {33'b0, pay_q[ST_ROOT].msum[31:1]};
	assign num_2 = {3'b000, pay_q[ST_ROOT].item.second_mass, 30'b0}
		+ {33'b0, pay_q[ST_ROOT].msum[31:1]};
	assign den_m = {2'b00, pay_q[ST_ROOT].msum};

	bpcr_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div_x (
		.clk(clk), .en(adv), .num(num_x), .den(dist_root), .quo(qx));
	bpcr_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div_y (
		.clk(clk), .en(adv), .num(num_y), .den(dist_root), .quo(qy));
	bpcr_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div_m1 (
		.clk(clk), .en(adv), .num(num_1), .den(den_m), .quo(q1));
	bpcr_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div_m2 (
		.clk(clk), .en(adv), .num(num_2), .den(den_m), .quo(q2));

	// ---- stage 71: normal products
	logic [63:0] pcx_s71, pcy_s71, p1x_s71, p1y_s71, p2x_s71, p2y_s71;
	always_ff @(posedge clk) begin
		if (adv) begin
			pcx_s71 <= pay_q[ST_QUO].corr * qx;
			pcy_s71 <= pay_q[ST_QUO].corr * qy;
			p1x_s71 <= mag32(pay_q[ST_QUO].item.first_vel_x) * qx;
			p1y_s71 <= mag32(pay_q[ST_QUO].item.first_vel_y) * qy;
			p2x_s71 <= mag32(pay_q[ST_QUO].item.second_vel_x) * qx;
			p2y_s71 <= mag32(pay_q[ST_QUO].item.second_vel_y) * qy;
		end
	end

	// ---- stage 72: round and sign
	logic signed [35:0] px_s72, py_s72, t1x_s72, t1y_s72, t2x_s72, t2y_s72;
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s72  <= sgn36(pay_q[ST_QUO+1].dx_neg, rnd30(pcx_s71));
			py_s72  <= sgn36(pay_q[ST_QUO+1].dy_neg, rnd30(pcy_s71));
			t1x_s72 <= sgn36(pay_q[ST_QUO+1].item.first_vel_x[31] ^ pay_q[ST_QUO+1].dx_neg,
				rnd30(p1x_s71));
			t1y_s72 <= sgn36(pay_q[ST_QUO+1].item.first_vel_y[31] ^ pay_q[ST_QUO+1].dy_neg,
				rnd30(p1y_s71));
			t2x_s72 <= sgn36(pay_q[ST_QUO+1].item.second_vel_x[31] ^ pay_q[ST_QUO+1].dx_neg,
				rnd30(p2x_s71));
			t2y_s72 <= sgn36(pay_q[ST_QUO+1].item.second_vel_y[31] ^ pay_q[ST_QUO+1].dy_neg,
				rnd30(p2y_s71));
		end
	end

	// ---- stage 73: normal speeds
	logic signed [36:0] v1_s73, v2_s73;
	always_ff @(posedge clk) begin
		if (adv) begin
			v1_s73 <= 37'(t1x_s72) + 37'(t1y_s72);
			v2_s73 <= 37'(t2x_s72) + 37'(t2y_s72);
		end
	end

	// ---- stage 74: closing speed
	logic signed [37:0] dv_d;
	logic [35:0]        dvm_s74;
	logic               dvn_s74;
	assign dv_d = 38'(v1_s73) - 38'(v2_s73);
	always_ff @(posedge clk) begin
		if (adv) begin
			dvm_s74 <= dv_d[37] ? 36'(-dv_d) : 36'(dv_d);
			dvn_s74 <= dv_d[37];
		end
	end

	// ---- stage 75: scale by one plus restitution
	logic [53:0] wkm_s75;
	logic        wkn_s75;
	always_ff @(posedge clk) begin
		if (adv) begin
			wkm_s75 <= dvm_s74 * (RESTI_ONE + {1'b0, restitution_q});
			wkn_s75 <= dvn_s74;
		end
	end

	// ---- stage 76: mass ratio partial products
	logic [58:0] pl1_s76, ph1_s76, pl2_s76, ph2_s76;
	logic        wkn_s76;
	always_ff @(posedge clk) begin
		if (adv) begin
			pl1_s76 <= wkm_s75[26:0] * pay_q[ST_QUO+5].q2;
			ph1_s76 <= wkm_s75[53:27] * pay_q[ST_QUO+5].q2;
			pl2_s76 <= wkm_s75[26:0] * pay_q[ST_QUO+5].q1;
			ph2_s76 <= wkm_s75[53:27] * pay_q[ST_QUO+5].q1;
			wkn_s76 <= wkn_s75;
		end
	end

	// ---- stage 77: velocity change magnitudes
	logic [85:0] s1_d, s2_d;
	logic [39:0] d1m_s77, d2m_s77;
	logic        d1n_s77, d2n_s77;
	logic        mzero_d;
	assign s1_d = {27'b0, pl1_s76} + {ph1_s76, 27'b0} + (86'd1 << 45);
	assign s2_d = {27'b0, pl2_s76} + {ph2_s76, 27'b0} + (86'd1 << 45);
	assign mzero_d = (pay_q[ST_QUO+6].msum == '0);
	always_ff @(posedge clk) begin
		if (adv) begin
			d1m_s77 <= mzero_d ? '0 : s1_d[85:46];
			d2m_s77 <= mzero_d ? '0 : s2_d[85:46];
			d1n_s77 <= !wkn_s76;
			d2n_s77 <= wkn_s76;
		end
	end

	// ---- stage 78: project back onto the axes, partial products
	logic [51:0] e1xl_s78, e1xh_s78, e1yl_s78, e1yh_s78;
	logic [51:0] e2xl_s78, e2xh_s78, e2yl_s78, e2yh_s78;
	logic        d1n_s78, d2n_s78;
	always_ff @(posedge clk) begin
		if (adv) begin
			e1xl_s78 <= d1m_s77[19:0]  * pay_q[ST_QUO+7].qx;
			e1xh_s78 <= d1m_s77[39:20] * pay_q[ST_QUO+7].qx;
			e1yl_s78 <= d1m_s77[19:0]  * pay_q[ST_QUO+7].qy;
			e1yh_s78 <= d1m_s77[39:20] * pay_q[ST_QUO+7].qy;
			e2xl_s78 <= d2m_s77[19:0]  * pay_q[ST_QUO+7].qx;
			e2xh_s78 <= d2m_s77[39:20] * pay_q[ST_QUO+7].qx;
			e2yl_s78 <= d2m_s77[19:0]  * pay_q[ST_QUO+7].qy;
			e2yh_s78 <= d2m_s77[39:20] * pay_q[ST_QUO+7].qy;
			d1n_s78  <= d1n_s77;
			d2n_s78  <= d2n_s77;
		end
	end

	// ---- stage 79: round and sign the axis deltas
	logic [71:0] r1x_d, r1y_d, r2x_d, r2y_d;
	logic signed [42:0] dv1x_s79, dv1y_s79, dv2x_s79, dv2y_s79;
	assign r1x_d = {20'b0, e1xl_s78} + {e1xh_s78, 20'b0} + 72'd536870912;
	assign r1y_d = {20'b0, e1yl_s78} + {e1yh_s78, 20'b0} + 72'd536870912;
	assign r2x_d = {20'b0, e2xl_s78} + {e2xh_s78, 20'b0} + 72'd536870912;
	assign r2y_d = {20'b0, e2yl_s78} + {e2yh_s78, 20'b0} + 72'd536870912;
	always_ff @(posedge clk) begin
		if (adv) begin
			dv1x_s79 <= sgn43(d1n_s78 ^ pay_q[ST_QUO+8].dx_neg, r1x_d[71:30]);
			dv1y_s79 <= sgn43(d1n_s78 ^ pay_q[ST_QUO+8].dy_neg, r1y_d[71:30]);
			dv2x_s79 <= sgn43(d2n_s78 ^ pay_q[ST_QUO+8].dx_neg, r2x_d[71:30]);
			dv2y_s79 <= sgn43(d2n_s78 ^ pay_q[ST_QUO+8].dy_neg, r2y_d[71:30]);
		end
	end

	// ---- stage 80: apply, saturate, result register
	bpcr_pay_t pl;
	bpcr_out_t out_d, out_s80;
	assign pl = pay_q[LAT-1];
	always_comb begin
		if (pl.collided) begin
			out_d.new_first_pos_x  = sat32(44'(pl.item.first_pos_x) - 44'(pl.px));
			out_d.new_first_pos_y  = sat32(44'(pl.item.first_pos_y) - 44'(pl.py));
			out_d.new_first_vel_x  = sat32(44'(pl.item.first_vel_x) + 44'(dv1x_s79));
			out_d.new_first_vel_y  = sat32(44'(pl.item.first_vel_y) + 44'(dv1y_s79));
			out_d.new_second_pos_x = sat32(44'(pl.item.second_pos_x) + 44'(pl.px));
			out_d.new_second_pos_y = sat32(44'(pl.item.second_pos_y) + 44'(pl.py));
			out_d.new_second_vel_x = sat32(44'(pl.item.second_vel_x) + 44'(dv2x_s79));
			out_d.new_second_vel_y = sat32(44'(pl.item.second_vel_y) + 44'(dv2y_s79));
			out_d.collided         = 1'b1;
		end else begin
			out_d.new_first_pos_x  = pl.item.first_pos_x;
			out_d.new_first_pos_y  = pl.item.first_pos_y;
			out_d.new_first_vel_x  = pl.item.first_vel_x;
			out_d.new_first_vel_y  = pl.item.first_vel_y;
			out_d.new_second_pos_x = pl.item.second_pos_x;
			out_d.new_second_pos_y = pl.item.second_pos_y;
			out_d.new_second_vel_x = pl.item.second_vel_x;
			out_d.new_second_vel_y = pl.item.second_vel_y;
			out_d.collided         = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s80 <= out_d;
		end
	end
	assign result.data = out_s80;

	// ---- side payload line, filled in where each value becomes known
	always_comb begin
		pay_in      = '0;
		pay_in.item = pair.data;
	end

	always_comb begin
		for (int k = 2; k < LAT; k++) begin
			pay_nxt[k] = pay_q[k-1];
		end
		pay_nxt[2].dx_neg = dx_d[32];
		pay_nxt[2].dy_neg = dy_d[32];
		pay_nxt[2].dx_mag = dx_d[32] ? 33'(-dx_d) : 33'(dx_d);
		pay_nxt[2].dy_mag = dy_d[32] ? 33'(-dy_d) : 33'(dy_d);
		pay_nxt[2].rsum   = {1'b0, pay_q[1].item.first_radius}
			+ {1'b0, pay_q[1].item.second_radius};
		pay_nxt[2].msum   = {1'b0, pay_q[1].item.first_mass}
			+ {1'b0, pay_q[1].item.second_mass};
		pay_nxt[ST_SUM].collided = coll_d;
		pay_nxt[ST_ROOT+1].corr  = gap_d[32:1];
		pay_nxt[ST_QUO+1].qx     = qx;
		pay_nxt[ST_QUO+1].qy     = qy;
		pay_nxt[ST_QUO+1].q1     = q1;
		pay_nxt[ST_QUO+1].q2     = q2;
		pay_nxt[ST_QUO+3].px     = px_s72;
		pay_nxt[ST_QUO+3].py     = py_s72;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_q[1] <= pay_in;
			for (int k = 2; k < LAT; k++) begin
				pay_q[k] <= pay_nxt[k];
			end
		end
	end

	// ---- checks
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !pair.ready)
		else $error("pair taken while the result beat is held");

	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[ST_ROOT] && pay_q[ST_ROOT].collided
		|-> (dist_root <= {2'b00, pay_q[ST_ROOT].rsum}) && (dist_root != '0))
		else $error("distance of a touching pair outside 1..radius sum");

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[ST_QUO] && pay_q[ST_QUO].collided
		|-> (qx <= UNIT_MAX) && (qy <= UNIT_MAX))
		else $error("normal component above one");

	a_mass_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[ST_QUO] && pay_q[ST_QUO].collided && (pay_q[ST_QUO].msum != '0)
		|-> ({1'b0, q1} + {1'b0, q2} >= 33'd1073741823)
		&& ({1'b0, q1} + {1'b0, q2} <= 33'd1073741825))
		else $error("mass ratios do not add up to one");

endmodule

[bench/ball_pair_collision_resolve_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ball_pair_collision_resolve_unit_tb
// Drives circle pairs through the collision resolve unit, in most phases under random source
// and sink idling. Each result beat is compared as a whole with a
// bit-exact software prediction of contact test, separation and restitution
// response, at several restitution settings.
// ----------------------------------------------------------------------------
module ball_pair_collision_resolve_unit_tb import bpcr_pkg::*;;

	localparam int DRAIN_CYCLES = 200;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [16:0] cfg_wdata = '0;

	bpcr_pair_if pair ();
	bpcr_result_if result ();

	ball_pair_collision_resolve_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pair     (pair),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	logic [16:0] resti;
	bpcr_out_t resolved_q[$];
	int mismatches = 0;
	longint cycles = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;

	typedef struct {
		bpcr_in_t   pair_in;
		bit         known;
		bpcr_out_t  outcome;
	} stim_row_t;
	stim_row_t rows[$];

	// ------------------------------------------------------------------
	// arithmetic helpers, 128-bit wide so nothing wraps
	function automatic logic signed [127:0] round_shift(logic signed [127:0] a,
			logic signed [127:0] b, int sh);
		logic [127:0] ma, mb, p;
		logic [255:0] full;
		logic neg;
		neg = (a < 0) != (b < 0);
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		full = ({128'd0, ma} * {128'd0, mb}) + (256'd1 << (sh - 1));
		full = full >> sh;
		if (full > 256'h7FFF_FFFF_FFFF_FFFF)
			p = 128'h7FFF_FFFF_FFFF_FFFF;
		else
			p = full[127:0];
		return neg ? -$signed(p) : $signed(p);
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
		if (v > 128'sh7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		if (v < -128'sh8000_0000)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [127:0] unit_q30(logic signed [127:0] num,
			logic [127:0] den);
		logic [127:0] m, q;
		m = num < 0 ? -num : num;
		q = ((m << 30) + den / 2) / den;
		return num < 0 ? -$signed(q) : $signed(q);
	endfunction

	function automatic bpcr_out_t resolve_pair(bpcr_in_t p, logic [16:0] e);
		bpcr_out_t o;
		logic signed [127:0] dx, dy, nx, ny, px, py, v1, v2, wk, d1, d2, q1, q2;
		logic [127:0] sq, rsum, msum, root_len, corr, c;
		dx = $signed(p.second_pos_x) - $signed(p.first_pos_x);
		dy = $signed(p.second_pos_y) - $signed(p.first_pos_y);
		sq = dx * dx + dy * dy;
		rsum = p.first_radius + p.second_radius;
		msum = p.first_mass + p.second_mass;
		o.new_first_pos_x = p.first_pos_x;
		o.new_first_pos_y = p.first_pos_y;
		o.new_first_vel_x = p.first_vel_x;
		o.new_first_vel_y = p.first_vel_y;
		o.new_second_pos_x = p.second_pos_x;
		o.new_second_pos_y = p.second_pos_y;
		o.new_second_vel_x = p.second_vel_x;
		o.new_second_vel_y = p.second_vel_y;
		o.collided = 1'b0;
		if (sq == 0 || sq > rsum * rsum)
			return o;
		root_len = 0;
		for (int b = 33; b >= 0; b--) begin
			c = root_len | (128'd1 << b);
			if (c * c <= sq)
				root_len = c;
		end
		corr = (rsum - root_len) >> 1;
		nx = unit_q30(dx, root_len);
		ny = unit_q30(dy, root_len);
		px = round_shift(corr, nx, 30);
		py = round_shift(corr, ny, 30);
		v1 = round_shift(p.first_vel_x, nx, 30) + round_shift(p.first_vel_y, ny, 30);
		v2 = round_shift(p.second_vel_x, nx, 30) + round_shift(p.second_vel_y, ny, 30);
		d1 = 0;
		d2 = 0;
		if (msum != 0) begin
			wk = (v1 - v2) * $signed({1'b0, 128'(RESTI_ONE) + e});
			q1 = ((128'(p.first_mass) << 30) + msum / 2) / msum;
			q2 = ((128'(p.second_mass) << 30) + msum / 2) / msum;
			d1 = -round_shift(wk, q2, 46);
			d2 = round_shift(wk, q1, 46);
		end
		o.new_first_pos_x = clamp32($signed(p.first_pos_x) - px);
		o.new_first_pos_y = clamp32($signed(p.first_pos_y) - py);
		o.new_first_vel_x = clamp32($signed(p.first_vel_x) + round_shift(d1, nx, 30));
		o.new_first_vel_y = clamp32($signed(p.first_vel_y) + round_shift(d1, ny, 30));
		o.new_second_pos_x = clamp32($signed(p.second_pos_x) + px);
		o.new_second_pos_y = clamp32($signed(p.second_pos_y) + py);
		o.new_second_vel_x = clamp32($signed(p.second_vel_x) + round_shift(d2, nx, 30));
		o.new_second_vel_y = clamp32($signed(p.second_vel_y) + round_shift(d2, ny, 30));
		o.collided = 1'b1;
		return o;
	endfunction

	// ------------------------------------------------------------------
	// stimulus generation
	function automatic logic [31:0] rnd_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
			default: return 32'($signed($urandom_range(0, 40000)) - 20000);
		endcase
	endfunction

	function automatic bpcr_in_t rnd_pair();
		bpcr_in_t p;
		int mode, near;
		mode = $urandom_range(0, 9);
		mode = mode == 0 ? 0 : (mode < 4 ? 1 : 2);
		near = $urandom_range(0, 3) != 0;
		p.first_pos_x = rnd_coord(mode);
		p.first_pos_y = rnd_coord(mode);
		p.first_vel_x = rnd_coord(mode);
		p.first_vel_y = rnd_coord(mode);
		p.second_vel_x = rnd_coord(mode);
		p.second_vel_y = rnd_coord(mode);
		p.first_mass = mode == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 22));
		p.second_mass = mode == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 22));
		if ($urandom_range(0, 15) == 0)
			p.first_mass = '0;
		if (near) begin
			// keep pairs close so most of them touch
			p.second_pos_x = p.first_pos_x + 32'($signed($urandom_range(0, 200000)) - 100000);
			p.second_pos_y = p.first_pos_y + 32'($signed($urandom_range(0, 200000)) - 100000);
			p.first_radius = 31'($urandom_range(0, 120000));
			p.second_radius = 31'($urandom_range(0, 120000));
		end else begin
			p.second_pos_x = rnd_coord(mode);
			p.second_pos_y = rnd_coord(mode);
			p.first_radius = mode == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 21));
			p.second_radius = mode == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 21));
		end
		return p;
	endfunction

	function automatic bpcr_in_t mk(logic [31:0] x1, y1, vx1, vy1, logic [30:0] r1, m1,
			logic [31:0] x2, y2, vx2, vy2, logic [30:0] r2, m2);
		bpcr_in_t p;
		p = '{x1, y1, vx1, vy1, r1, m1, x2, y2, vx2, vy2, r2, m2};
		return p;
	endfunction

	function automatic bpcr_out_t passthru(bpcr_in_t p);
		bpcr_out_t o;
		o = '{p.first_pos_x, p.first_pos_y, p.first_vel_x, p.first_vel_y,
			p.second_pos_x, p.second_pos_y, p.second_vel_x, p.second_vel_y, 1'b0};
		return o;
	endfunction

	function automatic void add_row(bpcr_in_t p, bit known, bpcr_out_t o);
		stim_row_t r;
		r.pair_in = p;
		r.known = known;
		r.outcome = o;
		rows.push_back(r);
	endfunction

	function automatic void build_table();
		bpcr_in_t p;
		bpcr_out_t o;
		localparam logic [31:0] ONE = 32'h0001_0000;
		localparam logic [31:0] MAXS = 32'h7FFF_FFFF;
		localparam logic [31:0] MINS = 32'h8000_0000;
		// coincident centres pass through
		p = mk(ONE, ONE, 5, -5, 31'h7FFF_FFFF, ONE, ONE, ONE, -7, 7, 31'h7FFF_FFFF, ONE);
		add_row(p, 1, passthru(p));
		// far apart, extreme coordinates
		p = mk(MINS, MINS, MAXS, MINS, 0, 31'h7FFF_FFFF, MAXS, MAXS, MINS, MAXS, 0, 0);
		add_row(p, 1, passthru(p));
		p = mk(MAXS, MINS, MINS, MAXS, 31'h7FFF_FFFF, 0, MINS, MAXS, MAXS, MINS,
			31'h7FFF_FFFF, 31'h7FFF_FFFF);
		add_row(p, 0, o);
		// just touching: overlap zero, head-on, equal masses
		p = mk(0, 0, ONE, 0, ONE, ONE, 32'h0002_0000, 0, -ONE, 0, ONE, ONE);
		add_row(p, 0, o);
		// one unit too far
		p = mk(0, 0, ONE, 0, ONE, ONE, 32'h0002_0001, 0, -ONE, 0, ONE, ONE);
		add_row(p, 1, passthru(p));
		// overlapping along x and y, zero mass sum
		p = mk(0, 0, ONE, ONE, ONE, 0, ONE, 0, 0, 0, ONE, 0);
		add_row(p, 0, o);
		p = mk(0, 0, ONE, ONE, ONE, 0, 0, -ONE, 0, 0, ONE, 0);
		add_row(p, 0, o);
		// diagonal with huge velocities, saturation
		p = mk(0, 0, MAXS, MAXS, ONE, 1, ONE, ONE, MINS, MINS, ONE, 31'h7FFF_FFFF);
		add_row(p, 0, o);
		p = mk(MAXS, MAXS, MAXS, MINS, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
			32'h7FFF_0000, 32'h7FFF_0000, MINS, MAXS, 31'h7FFF_FFFF, 1);
		add_row(p, 0, o);
		p = mk(MINS, MINS, MINS, MAXS, 31'h7FFF_FFFF, 1, 32'h8000_FFFF, MINS, MAXS, MINS,
			31'h7FFF_FFFF, 31'h7FFF_FFFF);
		add_row(p, 0, o);
		// zero radii, distance one unit
		p = mk(0, 0, 0, 0, 0, ONE, 1, 0, 0, 0, 0, ONE);
		add_row(p, 1, passthru(p));
		// all bits set / clear patterns
		p = mk('1, '1, '1, '1, '1, '1, '0, '0, '0, '0, '0, '0);
		add_row(p, 0, o);
		p = mk('0, '0, '0, '0, '0, '0, '1, '1, '1, '1, '1, '1);
		add_row(p, 0, o);
		p = mk(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 31'h5555_5555,
			31'h2AAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			31'h2AAA_AAAA, 31'h5555_5555);
		add_row(p, 0, o);
		for (int i = 0; i < 6; i++)
			add_row(rnd_pair(), 0, o);
	endfunction

	// ------------------------------------------------------------------
	task automatic send_pair(bpcr_in_t p);
		// drop valid only while idling, so back-to-back beats keep it high
		while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			pair.valid <= 1'b0;
			@(posedge clk);
		end
		pair.valid <= 1'b1;
		pair.data <= p;
		resolved_q.push_back(resolve_pair(p, resti));
		do
			@(posedge clk);
		while (!pair.ready);
	endtask

	task automatic drain();
		pair.valid <= 1'b0;
		while (resolved_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_resti(logic [16:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		resti = v;
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++)
			send_pair(rnd_pair());
	endtask

	// ------------------------------------------------------------------
	// result checking
	always @(posedge clk) begin
		if (arst_n) begin
			result.ready <= (snk_idle_pct == 0) || ($urandom_range(0, 99) >= snk_idle_pct);
			if (result.valid && result.ready) begin
				if (resolved_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat %p", result.data);
				end else begin
					bpcr_out_t want;
					want = resolved_q.pop_front();
					if (want !== result.data) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p got %p", want, result.data);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[ball_pair_collision_resolve_unit] ERROR");
			$finish;
		end
	end

	initial begin
		pair.valid = 1'b0;
		pair.data = '0;
		result.ready = 1'b0;
		resti = RESTI_RESET;
		build_table();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset restitution
		foreach (rows[i]) begin
			send_pair(rows[i].pair_in);
			if (rows[i].known)
				resolved_q[resolved_q.size() - 1] = rows[i].outcome;
		end
		drain();

		src_idle_pct = 11;
		snk_idle_pct = 53;
		write_resti(17'd0);
		random_phase(120);
		drain();
		write_resti(17'd65536);
		random_phase(120);
		drain();

		src_idle_pct = 53;
		snk_idle_pct = 11;
		write_resti(17'h1FFFF);
		random_phase(120);
		drain();
		write_resti(17'($urandom_range(0, 65536)));
		random_phase(120);
		drain();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_resti(17'd32768);
		random_phase(120);
		drain();
		write_resti(17'($urandom));
		random_phase(100);
		drain();

		if (mismatches == 0)
			$display("[ball_pair_collision_resolve_unit] OK");
		else
			$display("[ball_pair_collision_resolve_unit] ERROR");
		$finish;
	end

endmodule
